/* hdl/ssb_pkg.sv */
// Shared types, codes and fixed-point constants of the setpoint smoother bank.
package ssb_pkg;

  localparam int unsigned NUM_ENTRIES_DEF = 32;

  localparam int unsigned IDX_W  = 6;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned DIFF_W = 33;
  localparam int unsigned THR_W  = 16;
  localparam int unsigned T_W    = 17;

  // Tick fraction t saturates at 1.0 in Q16.16.
  localparam logic [T_W-1:0] ONE_Q = 17'h10000;

  // 2*pi in Q16.16, rounded. It is odd, so the nearest remainder never ties.
  localparam logic [18:0] TWO_PI_Q = 19'd411775;
  localparam logic [17:0] WRAP_HALF = 18'((TWO_PI_Q - 19'd1) / 2);

  // The wrap unit lifts its input by a multiple of 2*pi so the operand of the
  // reciprocal multiply is never negative, and stays below 2^34.
  localparam int unsigned WRAP_Z_W   = 34;
  localparam int unsigned WRAP_SHIFT = 34;
  localparam logic [63:0] TWO_PI_Q64 = 64'(TWO_PI_Q);
  localparam logic [WRAP_Z_W-1:0] WRAP_OFFSET = 34'(TWO_PI_Q64 * 64'd16384);
  localparam logic [15:0] WRAP_RECIP = 16'((64'd1 << WRAP_SHIFT) / TWO_PI_Q64);

  typedef enum logic [1:0] {
    MODE_SET   = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_LINEAR = 2'd1,
    KIND_ANGLE  = 2'd2
  } kind_e;

endpackage

/* hdl/ssb_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module ssb_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 32,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/ssb_wrap.sv */
// Three-stage pipelined wrap of a signed Q16.16 value to the nearest remainder of 2*pi.
module ssb_wrap (
  input  logic                                clk_i,
  input  logic signed [ssb_pkg::DIFF_W-1:0]   x_i,
  output logic signed [ssb_pkg::VAL_W-1:0]    y_o
);

  logic [35:0]                    z_full;
  logic [ssb_pkg::WRAP_Z_W-1:0]   z_a;
  logic [49:0]                    recip_prod;
  logic [ssb_pkg::WRAP_Z_W-1:0]   z_a_q;
  logic [15:0]                    quo_a_q;
  logic [ssb_pkg::WRAP_Z_W-1:0]   z_b_q;
  logic [34:0]                    qm_b_q;
  logic [ssb_pkg::WRAP_Z_W-1:0]   rem_full;
  logic [19:0]                    rem;
  logic [19:0]                    rem_fix;
  logic [20:0]                    res;
  logic signed [ssb_pkg::VAL_W-1:0] y_q;

  // Adding half a period turns the nearest remainder into a floor remainder.
  assign z_full = {{3{x_i[ssb_pkg::DIFF_W-1]}}, x_i} + 36'(ssb_pkg::WRAP_HALF)
                + 36'(ssb_pkg::WRAP_OFFSET);
  assign z_a = z_full[ssb_pkg::WRAP_Z_W-1:0];
  assign recip_prod = z_a * ssb_pkg::WRAP_RECIP;

  // The reciprocal estimate is low by at most one, so one correction suffices.
  assign rem_full = z_b_q - qm_b_q[ssb_pkg::WRAP_Z_W-1:0];
  assign rem      = rem_full[19:0];
  assign rem_fix  = (rem >= 20'(ssb_pkg::TWO_PI_Q)) ? rem - 20'(ssb_pkg::TWO_PI_Q) : rem;
  assign res      = {1'b0, rem_fix} - 21'(ssb_pkg::WRAP_HALF);

  always_ff @(posedge clk_i) begin
    z_a_q   <= z_a;
    quo_a_q <= recip_prod[49:ssb_pkg::WRAP_SHIFT];
    z_b_q   <= z_a_q;
    qm_b_q  <= quo_a_q * ssb_pkg::TWO_PI_Q;
    y_q     <= {{11{res[20]}}, res};
  end

  assign y_o = y_q;

endmodule

/* hdl/setpoint_smoother_bank_top.sv */
// Top level of the setpoint smoother bank: sequencer, update pipeline and result stage.
//
// A bank of NUM_ENTRIES smoothed parameters held in one RAM word per entry
// (target, current value, speed, kind), with active marks and entry valid bits
// in flip-flops, so reset and a clear item take effect at once and no clearing
// pass is needed. Items are taken one at a time. A clear, an ignored mode or a
// set to an index outside the bank is done in the S_IDLE state. A set goes
// through the read-modify-write pipeline; when it snaps, its result passes
// through the S_SNAP state into the output register, waiting while the output
// is held. A tick walks the RAM once, one entry per cycle, and after the
// pipeline drains it reads back each moved entry for its result, one transfer
// per cycle when the output is taken at once. A tick while nothing is updating
// is done in the S_IDLE state. The next item is accepted while the last result
// still waits in the output register.
module setpoint_smoother_bank_top #(
  parameter int unsigned NUM_ENTRIES = ssb_pkg::NUM_ENTRIES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ssb_pkg::THR_W-1:0] cfg_wdata_i,    // near_zero_threshold
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // param_index[5:0], target_value[37:6], interp_speed[69:38],
  // interp_kind[71:70], frame_time[103:72]
  input  logic [103:0]              s_axis_tdata_i,
  input  logic [1:0]                s_axis_tuser_i,  // mode[1:0]
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // out_index[5:0], out_value[37:6], any_active[38], zero fill[39]
  output logic [39:0]               m_axis_tdata_o,
  output logic                      m_axis_tlast_o   // last
);

  localparam int unsigned AW        = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int unsigned WB_STAGE  = 9;
  localparam int unsigned PIPE_LAT  = WB_STAGE + 1;
  localparam int unsigned CNT_W     = $clog2(NUM_ENTRIES + PIPE_LAT);

  typedef struct packed {
    logic [1:0]                       kind;
    logic [ssb_pkg::VAL_W-1:0]        spd;
    logic signed [ssb_pkg::VAL_W-1:0] cur;
    logic signed [ssb_pkg::VAL_W-1:0] tgt;
  } entry_t;

  typedef struct packed {
    logic                              vld;
    logic                              ent;
    logic [ssb_pkg::IDX_W-1:0]         idx;
  } issue_t;

  typedef struct packed {
    logic                              vld;
    logic [ssb_pkg::IDX_W-1:0]         idx;
    logic signed [ssb_pkg::VAL_W-1:0]  tgt;
    logic signed [ssb_pkg::VAL_W-1:0]  cur;
    logic [ssb_pkg::VAL_W-1:0]         spd;
    logic [1:0]                        kind;
    logic                              slow;
    logic signed [ssb_pkg::DIFF_W-1:0] diff;
    logic [63:0]                       prod;
    logic [ssb_pkg::T_W-1:0]           t;
    logic signed [50:0]                m;
    logic signed [33:0]                sum;
  } pipe_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_EMIT,
    S_SNAP
  } state_e;

  state_e                           state_q;
  logic [ssb_pkg::THR_W-1:0]        thr_q;
  logic [NUM_ENTRIES-1:0]           marks_q;
  logic [NUM_ENTRIES-1:0]           valid_q;
  logic                             updating_q;
  logic [CNT_W-1:0]                 iss_q;
  logic [NUM_ENTRIES-1:0]           em_q;
  logic                             any_acc_q;
  logic                             fetch_pend_q;
  logic                             fetch_last_q;
  logic [ssb_pkg::IDX_W-1:0]        fetch_idx_q;
  logic [ssb_pkg::IDX_W-1:0]        hold_idx_q;
  logic signed [ssb_pkg::VAL_W-1:0] hold_val_q;
  logic                             hold_any_q;
  logic                             out_vld_q;
  logic [ssb_pkg::IDX_W-1:0]        out_idx_q;
  logic signed [ssb_pkg::VAL_W-1:0] out_val_q;
  logic                             out_any_q;
  logic                             out_last_q;

  logic [1:0]                       item_mode_q;
  logic [ssb_pkg::IDX_W-1:0]        item_idx_q;
  logic signed [ssb_pkg::VAL_W-1:0] item_tgt_q;
  logic [ssb_pkg::VAL_W-1:0]        item_spd_q;
  logic [1:0]                       item_kind_q;
  logic [ssb_pkg::VAL_W-1:0]        item_ft_q;

  issue_t                           s0_q;
  pipe_t                            pipe_q [1:WB_STAGE];
  pipe_t                            pipe_d [1:WB_STAGE];

  logic                             in_xfer;
  logic                             in_idx_ok;
  logic                             item_tick;
  logic [CNT_W-1:0]                 n_issue;
  logic                             run_issue;
  logic                             run_done;
  logic                             out_free;

  logic                             ram_re;
  logic [AW-1:0]                    ram_raddr;
  logic                             ram_we;
  logic [AW-1:0]                    wb_addr;
  entry_t                           ram_wdata;
  entry_t                           ram_rdata;
  logic [$bits(entry_t)-1:0]        ram_rdata_raw;

  logic [NUM_ENTRIES-1:0]           em_low;
  logic [NUM_ENTRIES-1:0]           em_rest;
  logic [AW-1:0]                    em_low_idx;
  logic                             emit_load;
  logic                             emit_issue;

  entry_t                           s1_ent;
  logic signed [ssb_pkg::VAL_W-1:0] s1_tgt;
  logic [ssb_pkg::VAL_W-1:0]        s1_spd;
  logic [1:0]                       s1_kind;
  logic [63:0]                      s1_prod;
  logic [47:0]                      s2_prod_sh;
  logic signed [ssb_pkg::DIFF_W-1:0] s5_diff;

  logic signed [ssb_pkg::VAL_W-1:0] wrap_diff;
  logic signed [ssb_pkg::VAL_W-1:0] wrap_cur;

  pipe_t                            wb;
  logic                             wb_vld;
  logic [ssb_pkg::DIFF_W-1:0]       wb_mag;
  logic                             wb_nz;
  logic                             wb_snap;
  logic signed [ssb_pkg::VAL_W-1:0] wb_cur;
  logic [NUM_ENTRIES-1:0]           wb_bit;

  // Input side.
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_xfer   = s_axis_tvalid_i && s_axis_tready_o;
  assign in_idx_ok = ({1'b0, s_axis_tdata_i[5:0]} < 7'(NUM_ENTRIES));

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_mode_q <= s_axis_tuser_i;
      item_idx_q  <= s_axis_tdata_i[5:0];
      item_tgt_q  <= s_axis_tdata_i[37:6];
      item_spd_q  <= s_axis_tdata_i[69:38];
      item_kind_q <= s_axis_tdata_i[71:70];
      item_ft_q   <= s_axis_tdata_i[103:72];
    end
  end

  assign item_tick = (item_mode_q == ssb_pkg::MODE_TICK);
  assign n_issue   = item_tick ? CNT_W'(NUM_ENTRIES) : CNT_W'(1);
  assign run_issue = (state_q == S_RUN) && (iss_q < n_issue);
  assign run_done  = (state_q == S_RUN) && (iss_q == n_issue + CNT_W'(WB_STAGE));
  assign out_free  = !out_vld_q || m_axis_tready_i;

  // Result read-back: the lowest pending entry goes next, so results leave in index order.
  always_comb begin
    em_low     = em_q & (~em_q + NUM_ENTRIES'(1));
    em_rest    = em_q & ~em_low;
    em_low_idx = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (em_low[i]) begin
        em_low_idx = em_low_idx | AW'(i);
      end
    end
  end

  assign emit_load  = (state_q == S_EMIT) && fetch_pend_q && out_free;
  assign emit_issue = (state_q == S_EMIT) && (em_q != '0) && (!fetch_pend_q || emit_load);

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (state_q == S_RUN) begin
      ram_re    = run_issue;
      ram_raddr = item_tick ? iss_q[AW-1:0] : item_idx_q[AW-1:0];
    end else if (state_q == S_EMIT) begin
      ram_re    = emit_issue;
      ram_raddr = em_low_idx;
    end
  end

  ssb_ram #(
    .DATA_W ($bits(entry_t)),
    .DEPTH  (NUM_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wb_addr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  // Stage 1: an entry never written since reset or clear reads as zero.
  always_comb begin
    s1_ent  = s0_q.ent ? ram_rdata : '0;
    s1_tgt  = item_tick ? s1_ent.tgt : item_tgt_q;
    s1_spd  = item_tick ? s1_ent.spd : item_spd_q;
    s1_kind = item_tick ? s1_ent.kind : item_kind_q;
    s1_prod = item_ft_q * s1_spd;
  end

  always_comb begin
    s2_prod_sh = pipe_q[1].prod[63:16];
    for (int k = 2; k <= WB_STAGE; k++) begin
      pipe_d[k] = pipe_q[k-1];
    end

    pipe_d[1].vld  = s0_q.vld;
    pipe_d[1].idx  = s0_q.idx;
    pipe_d[1].tgt  = s1_tgt;
    pipe_d[1].cur  = s1_ent.cur;
    pipe_d[1].spd  = s1_spd;
    pipe_d[1].kind = s1_kind;
    pipe_d[1].slow = (s1_spd < 32'(thr_q));
    pipe_d[1].diff = {s1_tgt[31], s1_tgt} - {s1_ent.cur[31], s1_ent.cur};
    pipe_d[1].prod = s1_prod;
    pipe_d[1].t    = '0;
    pipe_d[1].m    = '0;
    pipe_d[1].sum  = '0;

    pipe_d[2].t = (s2_prod_sh > 48'(ssb_pkg::ONE_Q)) ? ssb_pkg::ONE_Q : s2_prod_sh[16:0];

    // A tick moves a snapping kind straight to its target with no distance left.
    if (pipe_q[4].kind == ssb_pkg::KIND_ANGLE) begin
      s5_diff = {wrap_diff[31], wrap_diff};
    end else if (item_tick && (pipe_q[4].kind != ssb_pkg::KIND_LINEAR)) begin
      s5_diff = '0;
    end else begin
      s5_diff = pipe_q[4].diff;
    end
    pipe_d[5].diff = s5_diff;
    pipe_d[5].m    = s5_diff * $signed({1'b0, pipe_q[4].t});

    // The arithmetic shift of the product floors toward minus infinity.
    pipe_d[6].sum = {{2{pipe_q[5].cur[31]}}, pipe_q[5].cur} + pipe_q[5].m[49:16];
  end

  ssb_wrap u_wrap_diff (
    .clk_i (clk_i),
    .x_i   (pipe_q[1].diff),
    .y_o   (wrap_diff)
  );

  ssb_wrap u_wrap_cur (
    .clk_i (clk_i),
    .x_i   (pipe_q[6].sum[32:0]),
    .y_o   (wrap_cur)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q <= '0;
      for (int k = 1; k <= WB_STAGE; k++) begin
        pipe_q[k] <= '0;
      end
    end else begin
      s0_q.vld <= run_issue && (!item_tick || marks_q[ram_raddr]);
      s0_q.ent <= valid_q[ram_raddr];
      s0_q.idx <= ssb_pkg::IDX_W'(ram_raddr);
      for (int k = 1; k <= WB_STAGE; k++) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  // Write-back stage.
  always_comb begin
    wb      = pipe_q[WB_STAGE];
    wb_vld  = (state_q == S_RUN) && wb.vld;
    wb_addr = wb.idx[AW-1:0];
    wb_bit  = NUM_ENTRIES'(1) << wb_addr;
    wb_mag  = wb.diff[32] ? 33'(-wb.diff) : 33'(wb.diff);
    wb_nz   = (wb_mag < 33'(thr_q));
    wb_snap = wb.slow || wb_nz;
    if (item_tick) begin
      if (wb_nz) begin
        wb_cur = wb.tgt;
      end else begin
        unique case (wb.kind)
          ssb_pkg::KIND_ANGLE:  wb_cur = wrap_cur;
          ssb_pkg::KIND_LINEAR: wb_cur = wb.sum[31:0];
          default:              wb_cur = wb.tgt;
        endcase
      end
    end else begin
      wb_cur = wb_snap ? wb.tgt : wb.cur;
    end
    ram_we    = wb_vld;
    ram_wdata = '{kind: wb.kind, spd: wb.spd, cur: wb_cur, tgt: wb.tgt};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      thr_q        <= ssb_pkg::THR_W'(1);
      marks_q      <= '0;
      valid_q      <= '0;
      updating_q   <= 1'b0;
      iss_q        <= '0;
      em_q         <= '0;
      any_acc_q    <= 1'b0;
      fetch_pend_q <= 1'b0;
      fetch_last_q <= 1'b0;
      fetch_idx_q  <= '0;
      hold_idx_q   <= '0;
      hold_val_q   <= '0;
      hold_any_q   <= 1'b0;
      out_vld_q    <= 1'b0;
      out_idx_q    <= '0;
      out_val_q    <= '0;
      out_any_q    <= 1'b0;
      out_last_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (out_vld_q && m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            iss_q     <= '0;
            em_q      <= '0;
            any_acc_q <= 1'b0;
            unique case (ssb_pkg::mode_e'(s_axis_tuser_i))
              ssb_pkg::MODE_SET: begin
                if (in_idx_ok) begin
                  state_q <= S_RUN;
                end
              end
              ssb_pkg::MODE_TICK: begin
                if (updating_q) begin
                  state_q <= S_RUN;
                end
              end
              ssb_pkg::MODE_CLEAR: begin
                valid_q    <= '0;
                marks_q    <= '0;
                updating_q <= 1'b0;
              end
              default: ;
            endcase
          end
        end

        S_RUN: begin
          iss_q <= iss_q + CNT_W'(1);
          if (wb_vld) begin
            if (item_tick) begin
              em_q <= em_q | wb_bit;
              if (wb_nz) begin
                marks_q <= marks_q & ~wb_bit;
              end else begin
                any_acc_q <= 1'b1;
              end
            end else begin
              valid_q    <= valid_q | wb_bit;
              hold_idx_q <= wb.idx;
              hold_val_q <= wb.tgt;
              hold_any_q <= |(marks_q & ~wb_bit);
              if (wb_snap) begin
                marks_q <= marks_q & ~wb_bit;
              end else begin
                marks_q    <= marks_q | wb_bit;
                updating_q <= 1'b1;
              end
            end
          end
          if (run_done) begin
            if (item_tick) begin
              state_q <= S_EMIT;
            end else begin
              state_q <= wb_snap ? S_SNAP : S_IDLE;
            end
          end
        end

        S_EMIT: begin
          // The RAM read data holds until the next read, so a fetched word
          // waits there while the output register is still occupied.
          if (emit_load) begin
            out_vld_q  <= 1'b1;
            out_idx_q  <= fetch_idx_q;
            out_val_q  <= ram_rdata.cur;
            out_any_q  <= any_acc_q;
            out_last_q <= fetch_last_q;
          end
          if (emit_issue) begin
            em_q         <= em_rest;
            fetch_pend_q <= 1'b1;
            fetch_idx_q  <= ssb_pkg::IDX_W'(em_low_idx);
            fetch_last_q <= (em_rest == '0);
          end else if (emit_load) begin
            fetch_pend_q <= 1'b0;
          end
          if ((em_q == '0) && !fetch_pend_q) begin
            state_q <= S_IDLE;
            if (!any_acc_q) begin
              updating_q <= 1'b0;
            end
          end
        end

        S_SNAP: begin
          if (out_free) begin
            out_vld_q  <= 1'b1;
            out_idx_q  <= hold_idx_q;
            out_val_q  <= hold_val_q;
            out_any_q  <= hold_any_q;
            out_last_q <= 1'b1;
            state_q    <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {1'b0, out_any_q, out_val_q, out_idx_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

/* test/setpoint_smoother_bank_top_tb.sv */
// Self-checking testbench of the setpoint smoother bank: directed and random stream traffic.
module setpoint_smoother_bank_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssb_pkg::*;

  localparam int NUM = NUM_ENTRIES_DEF;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam longint TWO_PI_L = longint'(TWO_PI_Q);
  localparam longint ONE_L = longint'(ONE_Q);
  localparam int SETTLE_CYCLES = 2 * NUM + 24;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 3000;
  localparam int REPORT_CAP = 200;
  localparam int DIR_ROWS = 25;

  typedef struct packed {
    logic [5:0]  idx;
    logic [31:0] val;
    logic        act;
    logic        lst;
  } bank_res_t;

  // One input item; typed rows carry their own expected result.
  typedef struct packed {
    logic [1:0]  mode;
    logic [5:0]  idx;
    logic [31:0] tgt;
    logic [31:0] spd;
    logic [1:0]  kind;
    logic [31:0] ft;
    logic        typed;
    logic        has_res;
    logic [31:0] res_val;
    logic        res_act;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [THR_W-1:0]  cfg_wdata_i = '0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [103:0]      s_axis_tdata_i = '0;
  logic [1:0]        s_axis_tuser_i = '0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [39:0]       m_axis_tdata_o;
  logic              m_axis_tlast_o;

  // Bank predictor state.
  logic signed [31:0] goal_bank [NUM];
  logic signed [31:0] cur_bank [NUM];
  logic [31:0]        rate_bank [NUM];
  logic [1:0]         kind_bank [NUM];
  logic               moving [NUM];
  logic               ticking;
  logic [THR_W-1:0]   thr_q = 16'd1;

  bank_res_t step_results [$];
  bank_res_t pending_results [$];

  int          mismatch_cnt = 0;
  int          report_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  int          sent_cnt = 0;

  stim_row_t dir_rows [DIR_ROWS] = '{
    // Tick straight after reset: nothing is updating.
    '{MODE_TICK, 6'd31, 32'h0, 32'h0, KIND_NONE, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 1'b0},
    // Zero speed snaps at once to the largest target.
    '{MODE_SET, 6'd0, 32'h7FFF_FFFF, 32'h0, KIND_LINEAR, 32'h0,
      1'b1, 1'b1, 32'h7FFF_FFFF, 1'b0},
    // Most negative target at full speed goes active.
    '{MODE_SET, 6'd31, 32'h8000_0000, 32'hFFFF_FFFF, KIND_LINEAR, 32'h0,
      1'b1, 1'b0, 32'h0, 1'b0},
    // Indexes outside the bank are ignored.
    '{MODE_SET, 6'd63, 32'h5, 32'h1_0000, KIND_LINEAR, 32'h0, 1'b1, 1'b0, 32'h0, 1'b0},
    '{MODE_SET, 6'd32, 32'h5, 32'h1_0000, KIND_LINEAR, 32'h0, 1'b1, 1'b0, 32'h0, 1'b0},
    '{MODE_SPARE, 6'h2A, 32'h5555_5555, 32'hAAAA_AAAA, KIND_SPARE, 32'h1234_5678,
      1'b1, 1'b0, 32'h0, 1'b0},
    // A one-second tick at saturated speed covers the whole distance.
    '{MODE_TICK, 6'd31, 32'h0, 32'h0, KIND_NONE, 32'h0001_0000,
      1'b1, 1'b1, 32'h8000_0000, 1'b1},
    // Zero-length tick sees no distance left and retires the entry.
    '{MODE_TICK, 6'd31, 32'h0, 32'h0, KIND_NONE, 32'h0, 1'b1, 1'b1, 32'h8000_0000, 1'b0},
    '{MODE_TICK, 6'd31, 32'h0, 32'h0, KIND_NONE, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 1'b0},
    '{MODE_SET, 6'd1, 32'h7FFF_FFFF, 32'h0000_8000, KIND_ANGLE, 32'h0,
      1'b0, 1'b0, 32'h0, 1'b0},
    '{MODE_SET, 6'd2, 32'h0003_0000, 32'h0001_0000, KIND_ANGLE, 32'h0,
      1'b0, 1'b0, 32'h0, 1'b0},
    '{MODE_SET, 6'd3, 32'hFFFD_0000, 32'h0002_0000, KIND_LINEAR, 32'h0,
      1'b0, 1'b0, 32'h0, 1'b0},
    '{MODE_SET, 6'd4, 32'h0000_03E8, 32'h0001_0000, KIND_NONE, 32'h0,
      1'b0, 1'b0, 32'h0, 1'b0},
    '{MODE_SET, 6'd5, 32'hFFFF_FFB3, 32'h0001_0000, KIND_SPARE, 32'h0,
      1'b0, 1'b0, 32'h0, 1'b0},
    // Angle targets just at and just past half a turn.
    '{MODE_SET, 6'd7, 32'h0003_243F, 32'h0000_4000, KIND_ANGLE, 32'h0,
      1'b0, 1'b0, 32'h0, 1'b0},
    '{MODE_SET, 6'd8, 32'h0003_2440, 32'h0000_4000, KIND_ANGLE, 32'h0,
      1'b0, 1'b0, 32'h0, 1'b0},
    '{MODE_TICK, 6'd0, 32'h0, 32'h0, KIND_NONE, 32'h0000_4000, 1'b0, 1'b0, 32'h0, 1'b0},
    '{MODE_TICK, 6'd0, 32'h0, 32'h0, KIND_NONE, 32'h0000_8000, 1'b0, 1'b0, 32'h0, 1'b0},
    '{MODE_TICK, 6'd0, 32'h0, 32'h0, KIND_NONE, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
    '{MODE_TICK, 6'd0, 32'h0, 32'h0, KIND_NONE, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
    '{MODE_CLEAR, 6'd0, 32'h0, 32'h0, KIND_NONE, 32'h0, 1'b1, 1'b0, 32'h0, 1'b0},
    '{MODE_TICK, 6'd0, 32'h0, 32'h0, KIND_NONE, 32'h0001_0000, 1'b1, 1'b0, 32'h0, 1'b0},
    // Target equal to the cleared value snaps even at full speed.
    '{MODE_SET, 6'd9, 32'h0, 32'hFFFF_FFFF, KIND_LINEAR, 32'h0, 1'b1, 1'b1, 32'h0, 1'b0},
    '{MODE_SET, 6'd10, 32'h1234_5678, 32'h0001_0000, KIND_ANGLE, 32'h0,
      1'b0, 1'b0, 32'h0, 1'b0},
    '{MODE_TICK, 6'd0, 32'h0, 32'h0, KIND_NONE, 32'h0002_0000, 1'b0, 1'b0, 32'h0, 1'b0}
  };

  always #1 clk_i = ~clk_i;

  setpoint_smoother_bank_top #(
    .NUM_ENTRIES(NUM)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  function automatic void clear_bank();
    int i;
    for (i = 0; i < NUM; i++) begin
      goal_bank[i] = '0;
      cur_bank[i] = '0;
      rate_bank[i] = '0;
      kind_bank[i] = KIND_NONE;
      moving[i] = 1'b0;
    end
    ticking = 1'b0;
  endfunction

  // Nearest remainder modulo 2*pi; the odd modulus rules out ties.
  function automatic longint wrap_2pi(input longint x);
    longint q;
    longint r;
    q = x / TWO_PI_L;
    r = x - q * TWO_PI_L;
    if (r < 0) r = r + TWO_PI_L;
    if (2 * r > TWO_PI_L) r = r - TWO_PI_L;
    return r;
  endfunction

  function automatic logic below_thr(input longint x);
    longint m;
    m = (x < 0) ? -x : x;
    return m < longint'(thr_q);
  endfunction

  function automatic logic any_moving();
    int i;
    for (i = 0; i < NUM; i++) begin
      if (moving[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Applies one item to the bank and leaves the results it causes in step_results.
  function automatic void advance_bank(input stim_row_t row);
    longint d;
    longint c;
    longint t;
    longint unsigned prod;
    logic still;
    bank_res_t r;
    int e;
    int i;
    step_results.delete();
    e = int'(row.idx);
    case (row.mode)
      MODE_SET: begin
        if (e < NUM) begin
          goal_bank[e] = row.tgt;
          rate_bank[e] = row.spd;
          kind_bank[e] = row.kind;
          d = longint'($signed(row.tgt)) - longint'(cur_bank[e]);
          if (row.kind == KIND_ANGLE) d = wrap_2pi(d);
          if (row.spd < {16'h0, thr_q} || below_thr(d)) begin
            cur_bank[e] = row.tgt;
            moving[e] = 1'b0;
            r.idx = row.idx;
            r.val = row.tgt;
            r.act = any_moving();
            r.lst = 1'b1;
            step_results.push_back(r);
          end else begin
            moving[e] = 1'b1;
            ticking = 1'b1;
          end
        end
      end
      MODE_TICK: begin
        if (ticking) begin
          still = 1'b0;
          for (i = 0; i < NUM; i++) begin
            if (moving[i]) begin
              prod = 64'(row.ft) * 64'(rate_bank[i]);
              if ((prod >> 16) > 64'd65536) t = ONE_L;
              else t = longint'(prod >> 16);
              c = longint'(cur_bank[i]);
              d = 0;
              if (kind_bank[i] == KIND_ANGLE) begin
                d = wrap_2pi(longint'(goal_bank[i]) - c);
                c = wrap_2pi(c + ((d * t) >>> 16));
              end else if (kind_bank[i] == KIND_LINEAR) begin
                d = longint'(goal_bank[i]) - c;
                c = c + ((d * t) >>> 16);
              end else begin
                c = longint'(goal_bank[i]);
              end
              if (below_thr(d)) begin
                c = longint'(goal_bank[i]);
                moving[i] = 1'b0;
              end else begin
                still = 1'b1;
              end
              cur_bank[i] = c[31:0];
              r.idx = 6'(i);
              r.val = c[31:0];
              r.act = 1'b0;
              r.lst = 1'b0;
              step_results.push_back(r);
            end
          end
          if (!still) ticking = 1'b0;
          foreach (step_results[k]) step_results[k].act = still;
          if (step_results.size() > 0) step_results[step_results.size() - 1].lst = 1'b1;
        end
      end
      MODE_CLEAR: clear_bank();
      default: ;
    endcase
  endfunction

  task automatic offer(input stim_row_t row);
    bank_res_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= row.mode;
    s_axis_tdata_i <= {row.ft, row.kind, row.spd, row.tgt, row.idx};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    advance_bank(row);
    if (row.typed) begin
      if (row.has_res) begin
        r.idx = row.idx;
        r.val = row.res_val;
        r.act = row.res_act;
        r.lst = 1'b1;
        pending_results.push_back(r);
      end
    end else begin
      foreach (step_results[k]) pending_results.push_back(step_results[k]);
    end
    sent_cnt++;
  endtask

  function automatic stim_row_t gen_set();
    stim_row_t r;
    int e;
    int v;
    int unsigned pick;
    r = '0;
    r.mode = MODE_SET;
    if ($urandom_range(0, 9) == 0) e = int'($urandom_range(NUM, 63));
    else e = int'($urandom_range(0, NUM - 1));
    r.idx = 6'(e);
    pick = $urandom_range(0, 9);
    if (pick < 4) r.kind = KIND_LINEAR;
    else if (pick < 8) r.kind = KIND_ANGLE;
    else if (pick == 8) r.kind = KIND_NONE;
    else r.kind = KIND_SPARE;
    pick = $urandom_range(0, 3);
    if (pick == 1) begin
      v = int'($urandom_range(0, 600000)) - 300000;
      r.tgt = v;
    end else if (pick >= 2 && e < NUM) begin
      // Land close to the present value so near-zero snaps happen.
      v = int'(cur_bank[e]) + int'($urandom_range(0, 2 * int'(thr_q) + 8)) - int'(thr_q) - 4;
      r.tgt = v;
    end else begin
      r.tgt = $urandom;
    end
    pick = $urandom_range(0, 7);
    if (pick == 0) r.spd = '0;
    else if (pick == 1) r.spd = $urandom;
    else if (pick == 2) r.spd = $urandom_range(0, 70000);
    else r.spd = $urandom_range(32'h1000, 32'h8_0000);
    r.ft = $urandom;
    return r;
  endfunction

  function automatic stim_row_t gen_tick();
    stim_row_t r;
    int unsigned pick;
    r = '0;
    r.mode = MODE_TICK;
    r.idx = 6'($urandom);
    r.tgt = $urandom;
    r.spd = $urandom;
    r.kind = 2'($urandom);
    pick = $urandom_range(0, 7);
    if (pick == 0) r.ft = '0;
    else if (pick == 1) r.ft = $urandom;
    else if (pick == 2) r.ft = 32'hFFFF_FFFF;
    else r.ft = $urandom_range(32'h100, 32'h6000);
    return r;
  endfunction

  // A few sets followed by ticks that let them settle, now and then a stray item.
  task automatic run_burst();
    stim_row_t r;
    int n;
    int unsigned pick;
    n = int'($urandom_range(1, 6));
    repeat (n) offer(gen_set());
    n = int'($urandom_range(1, 8));
    repeat (n) offer(gen_tick());
    pick = $urandom_range(0, 11);
    if (pick <= 2) begin
      r = '0;
      r.mode = 2'($urandom);
      r.idx = 6'($urandom);
      r.tgt = $urandom;
      r.spd = $urandom;
      r.kind = 2'($urandom);
      r.ft = $urandom;
      if (pick == 0) r.mode = MODE_CLEAR;
      else if (pick == 1) r.mode = MODE_SPARE;
      offer(r);
    end
  endtask

  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] v);
    cfg_wdata_i <= v;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    thr_q = v;
  endtask

  task automatic run_phase(input logic [THR_W-1:0] thr, input int unsigned sp,
                           input int unsigned rp, input int budget, input bit press);
    settle();
    write_threshold(thr);
    send_idle_pct = sp;
    recv_stall_pct = rp;
    if (press) hold_req = 1'b1;
    sent_cnt = 0;
    while (sent_cnt < budget) run_burst();
  endtask

  task automatic check_field(input string what, input logic [31:0] w, input logic [31:0] g);
    if (w !== g) begin
      mismatch_cnt++;
      report_cnt++;
      if (report_cnt <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, what, w, g);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off when asked.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    bank_res_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        report_cnt++;
        if (report_cnt <= REPORT_CAP)
          $display("%0t: result transfer with none expected, expected nothing, got %h last %b",
                   $realtime, m_axis_tdata_o, m_axis_tlast_o);
      end else begin
        want = pending_results.pop_front();
        check_field("out_index", 32'(want.idx), 32'(m_axis_tdata_o[5:0]));
        check_field("out_value", want.val, m_axis_tdata_o[37:6]);
        check_field("any_active", 32'(want.act), 32'(m_axis_tdata_o[38]));
        check_field("last", 32'(want.lst), 32'(m_axis_tlast_o));
      end
    end
  end

  // Watchdog: a long stretch without any transfer means the block hung.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    clear_bank();
    thr_q = 16'd1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) offer(dir_rows[k]);

    run_phase(16'hFFFF, 0, 0, 50, 1'b0);
    run_phase(16'h0000, 60, 0, 50, 1'b0);
    run_phase(16'h0001, 0, 60, 50, 1'b0);
    run_phase(THR_W'($urandom_range(2, 4000)), 10, 10, 50, 1'b0);
    run_phase(16'd300, 0, 0, 50, 1'b1);
    settle();

    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/ssb_pkg.sv
hdl/ssb_ram.sv
hdl/ssb_wrap.sv
hdl/setpoint_smoother_bank_top.sv
test/setpoint_smoother_bank_top_tb.sv
